// ----- rtl/core/pes_hp_pkg.sv -----
// ----------------------------------------------------------------------------
// pes_hp_pkg
// Shared types and constants of the PES header parser: the command word that
// travels from the front end to the back end, status codes and stream id
// ranges.
// ----------------------------------------------------------------------------
`default_nettype none

package pes_hp_pkg;

    // result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_PREFIX = 2'd1;
    localparam logic [1:0] STATUS_BAD_MARKER = 2'd2;
    localparam logic [1:0] STATUS_TRUNCATED  = 2'd3;

    // byte positions of the fixed and optional header fields
    localparam logic [4:0] POS_ID      = 5'd3;
    localparam logic [4:0] POS_LEN_HI  = 5'd4;
    localparam logic [4:0] POS_LEN_LO  = 5'd5;
    localparam logic [4:0] POS_FLAGS   = 5'd7;
    localparam logic [4:0] POS_HDR_LEN = 5'd8;
    localparam logic [4:0] POS_PTS0    = 5'd9;
    localparam logic [4:0] POS_PTS1    = 5'd10;
    localparam logic [4:0] POS_PTS2    = 5'd11;
    localparam logic [4:0] POS_PTS3    = 5'd12;
    localparam logic [4:0] POS_PTS4    = 5'd13;
    localparam logic [4:0] POS_DTS0    = 5'd14;
    localparam logic [4:0] POS_DTS1    = 5'd15;
    localparam logic [4:0] POS_DTS2    = 5'd16;
    localparam logic [4:0] POS_DTS3    = 5'd17;
    localparam logic [4:0] POS_DTS4    = 5'd18;
    localparam logic [4:0] POS_NONE    = 5'd31;

    // stream id ranges
    localparam logic [7:0] ID_AUDIO_LO   = 8'hc0;
    localparam logic [7:0] ID_AUDIO_HI   = 8'hdf;
    localparam logic [7:0] ID_VIDEO_LO   = 8'he0;
    localparam logic [7:0] ID_VIDEO_HI   = 8'hef;
    localparam logic [7:0] ID_PRIVATE_1  = 8'hbd;
    localparam logic [7:0] ID_PRIVATE_2  = 8'hbf;

    localparam logic [7:0] MARKER_MASK   = 8'hc0;
    localparam logic [7:0] MARKER_VALUE  = 8'h80;
    localparam logic [7:0] FLAG_PTS      = 8'h80;
    localparam logic [7:0] FLAG_DTS      = 8'h40;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] data_byte;
        logic [4:0] pos;
        logic       emit;
        logic [1:0] status;
    } cmd_t;

    function automatic logic id_ok(input logic [7:0] id);
        id_ok = (id >= ID_AUDIO_LO && id <= ID_AUDIO_HI) ||
                (id >= ID_VIDEO_LO && id <= ID_VIDEO_HI) ||
                (id == ID_PRIVATE_1) || (id == ID_PRIVATE_2);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pes_hp_front.sv -----
// ----------------------------------------------------------------------------
// pes_hp_front
// Byte front end: tracks the byte position, checks prefix and marker bits,
// finds header end or truncation and issues one command per header byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_hp_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_data_byte,
    input  wire logic          s_last_byte,
    input  wire logic          q_full,
    output logic               q_push,
    output pes_hp_pkg::cmd_t   q_cmd
);
    import pes_hp_pkg::*;

    localparam logic PHASE_HEADER = 1'b0;
    localparam logic PHASE_SKIP   = 1'b1;

    logic       phase_reg, phase_next;
    logic [8:0] count_reg, count_next;
    logic [7:0] hdr_len_reg, hdr_len_next;

    logic       accept;
    logic [1:0] err;
    logic [7:0] hl_eff;
    logic       done;
    logic       emit;

    assign s_ready = (phase_reg == PHASE_SKIP) || !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && (phase_reg == PHASE_HEADER);

    always_comb begin
        err = STATUS_OK;
        if ((count_reg == 9'd0 || count_reg == 9'd1) && s_data_byte != 8'h00) begin
            err = STATUS_BAD_PREFIX;
        end else if (count_reg == 9'd2 && s_data_byte != 8'h01) begin
            err = STATUS_BAD_PREFIX;
        end else if (count_reg == 9'd6 && (s_data_byte & MARKER_MASK) != MARKER_VALUE) begin
            err = STATUS_BAD_MARKER;
        end
    end

    // header length byte counts toward the end check in its own cycle
    assign hl_eff = (count_reg == 9'd8) ? s_data_byte : hdr_len_reg;
    assign done   = (count_reg >= 9'd8) && (count_reg == ({1'b0, hl_eff} + 9'd8));
    assign emit   = (err != STATUS_OK) || done || s_last_byte;

    always_comb begin
        q_cmd.data_byte = s_data_byte;
        q_cmd.pos       = (count_reg < 9'd19) ? count_reg[4:0] : POS_NONE;
        q_cmd.emit      = emit;
        priority if (err != STATUS_OK) begin
            q_cmd.status = err;
        end else if (done) begin
            q_cmd.status = STATUS_OK;
        end else begin
            q_cmd.status = STATUS_TRUNCATED;
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        hdr_len_next = hdr_len_reg;
        if (accept) begin
            unique case (phase_reg)
                PHASE_HEADER: begin
                    if (count_reg == 9'd8) begin
                        hdr_len_next = s_data_byte;
                    end
                    if (emit) begin
                        count_next = 9'd0;
                        phase_next = s_last_byte ? PHASE_HEADER : PHASE_SKIP;
                    end else begin
                        count_next = count_reg + 9'd1;
                    end
                end
                default: begin
                    if (s_last_byte) begin
                        phase_next = PHASE_HEADER;
                        count_next = 9'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PHASE_HEADER;
            count_reg   <= 9'd0;
            hdr_len_reg <= 8'd0;
        end else begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            hdr_len_reg <= hdr_len_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pes_hp_queue.sv -----
// ----------------------------------------------------------------------------
// pes_hp_queue
// Short command queue between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_hp_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire pes_hp_pkg::cmd_t  push_cmd,
    output logic                   full,
    input  wire logic              pop,
    output pes_hp_pkg::cmd_t       pop_cmd,
    output logic                   empty
);
    import pes_hp_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;

    assign full    = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pes_hp_back.sv -----
// ----------------------------------------------------------------------------
// pes_hp_back
// Back end: captures header fields and time stamps from the commands and
// builds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_hp_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire pes_hp_pkg::cmd_t  cmd,
    input  wire logic              q_empty,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_status,
    output logic [7:0]             m_stream_id,
    output logic                   m_id_supported,
    output logic [15:0]            m_pes_length,
    output logic [8:0]             m_payload_offset,
    output logic                   m_have_pts,
    output logic [32:0]            m_pts,
    output logic                   m_have_dts,
    output logic [32:0]            m_dts
);
    import pes_hp_pkg::*;

    logic [7:0]  id_reg, id_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  flags_reg, flags_next;
    logic [7:0]  hdr_len_reg, hdr_len_next;
    logic [32:0] pts_reg, pts_next;
    logic [32:0] dts_reg, dts_next;

    logic        out_valid_reg, out_valid_next;
    logic        load;
    logic [7:0]  b;
    logic        hp, hd;
    logic [16:0] hl_plus3;

    logic [1:0]  status_reg;
    logic [7:0]  stream_id_reg;
    logic        id_sup_reg;
    logic [15:0] pes_len_reg;
    logic [8:0]  offset_reg;
    logic        have_pts_reg, have_dts_reg;
    logic [32:0] pts_out_reg, dts_out_reg;

    assign b     = cmd.data_byte;
    // a command without a result never waits on the output register
    assign q_pop = !q_empty && (!cmd.emit || !out_valid_reg || m_ready);
    assign load  = q_pop && cmd.emit;

    always_comb begin
        id_next      = id_reg;
        length_next  = length_reg;
        flags_next   = flags_reg;
        hdr_len_next = hdr_len_reg;
        pts_next     = pts_reg;
        dts_next     = dts_reg;
        case (cmd.pos)
            POS_ID:      id_next = b;
            POS_LEN_HI:  length_next = {b, 8'h00};
            POS_LEN_LO:  length_next = {length_reg[15:8], b};
            POS_FLAGS:   flags_next = b;
            POS_HDR_LEN: hdr_len_next = b;
            POS_PTS0:    pts_next = {b[3:1], 30'd0};
            POS_PTS1:    pts_next = pts_reg | {3'd0, b, 22'd0};
            POS_PTS2:    pts_next = pts_reg | {11'd0, b[7:1], 15'd0};
            POS_PTS3:    pts_next = pts_reg | {18'd0, b, 7'd0};
            POS_PTS4:    pts_next = pts_reg | {26'd0, b[7:1]};
            POS_DTS0:    dts_next = {b[3:1], 30'd0};
            POS_DTS1:    dts_next = dts_reg | {3'd0, b, 22'd0};
            POS_DTS2:    dts_next = dts_reg | {11'd0, b[7:1], 15'd0};
            POS_DTS3:    dts_next = dts_reg | {18'd0, b, 7'd0};
            POS_DTS4:    dts_next = dts_reg | {26'd0, b[7:1]};
            default: begin
            end
        endcase
    end

    assign hp       = ((flags_next & FLAG_PTS) != 8'd0) && (hdr_len_next >= 8'd5);
    assign hd       = hp && ((flags_next & FLAG_DTS) != 8'd0) && (hdr_len_next >= 8'd10);
    assign hl_plus3 = {9'd0, hdr_len_next} + 17'd3;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg <= cmd.status;
            if (cmd.status == STATUS_OK) begin
                stream_id_reg <= id_next;
                id_sup_reg    <= id_ok(id_next);
                if ({1'b0, length_next} > hl_plus3) begin
                    pes_len_reg <= length_next - hl_plus3[15:0];
                end else begin
                    pes_len_reg <= length_next;
                end
                offset_reg   <= {1'b0, hdr_len_next} + 9'd9;
                have_pts_reg <= hp;
                pts_out_reg  <= hp ? pts_next : 33'd0;
                have_dts_reg <= hd;
                dts_out_reg  <= hd ? dts_next : 33'd0;
            end else begin
                stream_id_reg <= 8'd0;
                id_sup_reg    <= 1'b0;
                pes_len_reg   <= 16'd0;
                offset_reg    <= 9'd0;
                have_pts_reg  <= 1'b0;
                pts_out_reg   <= 33'd0;
                have_dts_reg  <= 1'b0;
                dts_out_reg   <= 33'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            id_reg        <= 8'd0;
            length_reg    <= 16'd0;
            flags_reg     <= 8'd0;
            hdr_len_reg   <= 8'd0;
            pts_reg       <= 33'd0;
            dts_reg       <= 33'd0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (q_pop) begin
                id_reg      <= id_next;
                length_reg  <= length_next;
                flags_reg   <= flags_next;
                hdr_len_reg <= hdr_len_next;
                pts_reg     <= pts_next;
                dts_reg     <= dts_next;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = status_reg;
    assign m_stream_id      = stream_id_reg;
    assign m_id_supported   = id_sup_reg;
    assign m_pes_length     = pes_len_reg;
    assign m_payload_offset = offset_reg;
    assign m_have_pts       = have_pts_reg;
    assign m_pts            = pts_out_reg;
    assign m_have_dts       = have_dts_reg;
    assign m_dts            = dts_out_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pes_header_parser_top.sv -----
// ----------------------------------------------------------------------------
// pes_header_parser_top
// MPEG-2 PES header parser: one packet byte per transaction in, one result
// per packet out.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while the queue has room and gives one
// result per packet, at the last header byte or at the first error (bad
// prefix, bad marker, truncation); the remaining bytes up to the last flag are
// swallowed. The front end classifies each byte and writes a command into a
// four-entry queue, and the back end retires one command per cycle, unless a
// result waits on the output, into the result register; a result passes the
// queue and then the result register. Bytes keep flowing while a result waits
// until the queue fills; bytes after a result are taken even then.
`default_nettype none

module pes_header_parser_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [7:0]       m_stream_id,
    output logic             m_id_supported,
    output logic [15:0]      m_pes_length,
    output logic [8:0]       m_payload_offset,
    output logic             m_have_pts,
    output logic [32:0]      m_pts,
    output logic             m_have_dts,
    output logic [32:0]      m_dts
);
    import pes_hp_pkg::*;

    cmd_t push_cmd, pop_cmd;
    logic q_push, q_full, q_pop, q_empty;

    pes_hp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    pes_hp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    pes_hp_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (pop_cmd),
        .q_empty          (q_empty),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_stream_id      (m_stream_id),
        .m_id_supported   (m_id_supported),
        .m_pes_length     (m_pes_length),
        .m_payload_offset (m_payload_offset),
        .m_have_pts       (m_have_pts),
        .m_pts            (m_pts),
        .m_have_dts       (m_have_dts),
        .m_dts            (m_dts)
    );

endmodule

`default_nettype wire

// ----- verif/pes_result_checker.sv -----
// ----------------------------------------------------------------------------
// pes_result_checker
// Watches both channels of the PES header parser, predicts one result per
// packet from the accepted bytes and compares every result field by field.
// ----------------------------------------------------------------------------
module pes_result_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [1:0]  m_status,
    input  wire logic [7:0]  m_stream_id,
    input  wire logic        m_id_supported,
    input  wire logic [15:0] m_pes_length,
    input  wire logic [8:0]  m_payload_offset,
    input  wire logic        m_have_pts,
    input  wire logic [32:0] m_pts,
    input  wire logic        m_have_dts,
    input  wire logic [32:0] m_dts,
    output int               mismatches,
    output int               outstanding
);
    import pes_hp_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  stream_id;
        logic        id_supported;
        logic [15:0] pes_length;
        logic [8:0]  payload_offset;
        logic        have_pts;
        logic [32:0] pts;
        logic        have_dts;
        logic [32:0] dts;
    } pes_result_t;

    pes_result_t result_q [$];

    // parser state as seen from the byte stream
    logic [8:0]  hdr_pos   = '0;
    logic        skipping  = 1'b0;
    logic [7:0]  id_q      = '0;
    logic [15:0] len_q     = '0;
    logic [7:0]  flags_q   = '0;
    logic [7:0]  hlen_q    = '0;
    logic [32:0] pts_q     = '0;
    logic [32:0] dts_q     = '0;
    int          err_total = 0;

    assign mismatches = err_total;

    function automatic logic stream_known(input logic [7:0] id);
        return (id >= ID_AUDIO_LO && id <= ID_VIDEO_HI) ||
               id == ID_PRIVATE_1 || id == ID_PRIVATE_2;
    endfunction

    // folds byte k of a five-byte time stamp field into the 33-bit value
    function automatic logic [32:0] merge_ts(input logic [32:0] acc, input int k,
                                             input logic [7:0] b);
        logic [32:0] whole;
        logic [32:0] upper7;
        whole  = {25'd0, b};
        upper7 = {26'd0, b[7:1]};
        case (k)
            0: return {b[3:1], 30'd0};
            1: return acc | (whole << 22);
            2: return acc | (upper7 << 15);
            3: return acc | (whole << 7);
            default: return acc | upper7;
        endcase
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic last);
        pes_result_t r;
        logic [1:0]  err;
        logic        done;
        logic        hp;
        logic        hd;
        logic [15:0] hdr_total;
        r    = '0;
        err  = STATUS_OK;
        done = 1'b0;
        if (skipping) begin
            if (last) begin
                skipping = 1'b0;
                hdr_pos  = '0;
            end
        end else begin
            case (hdr_pos)
                9'd0, 9'd1: if (b != 8'h00) err = STATUS_BAD_PREFIX;
                9'd2: if (b != 8'h01) err = STATUS_BAD_PREFIX;
                POS_ID: id_q = b;
                POS_LEN_HI: len_q = {b, 8'h00};
                POS_LEN_LO: len_q[7:0] = b;
                9'd6: if ((b & MARKER_MASK) != MARKER_VALUE) err = STATUS_BAD_MARKER;
                POS_FLAGS: flags_q = b;
                POS_HDR_LEN: hlen_q = b;
                default: begin
                    if (hdr_pos <= POS_PTS4)
                        pts_q = merge_ts(pts_q, hdr_pos - POS_PTS0, b);
                    else if (hdr_pos <= POS_DTS4)
                        dts_q = merge_ts(dts_q, hdr_pos - POS_DTS0, b);
                end
            endcase

            if (err != STATUS_OK) begin
                r.status = err;
                done     = 1'b1;
            end else if (hdr_pos >= POS_HDR_LEN && hdr_pos == 9'd8 + hlen_q) begin
                hp        = ((flags_q & FLAG_PTS) != 0) && hlen_q >= 8'd5;
                hd        = hp && ((flags_q & FLAG_DTS) != 0) && hlen_q >= 8'd10;
                hdr_total = {8'd0, hlen_q} + 16'd3;
                r.status         = STATUS_OK;
                r.stream_id      = id_q;
                r.id_supported   = stream_known(id_q);
                r.pes_length     = (len_q > hdr_total) ? len_q - hdr_total : len_q;
                r.payload_offset = 9'd9 + hlen_q;
                r.have_pts       = hp;
                r.pts            = hp ? pts_q : '0;
                r.have_dts       = hd;
                r.dts            = hd ? dts_q : '0;
                done             = 1'b1;
            end else if (last) begin
                r.status = STATUS_TRUNCATED;
                done     = 1'b1;
            end else begin
                hdr_pos = hdr_pos + 9'd1;
            end

            if (done) begin
                result_q.push_back(r);
                skipping = !last;
                hdr_pos  = '0;
            end
        end
    endtask

    task automatic check_field(input string fname, input logic [32:0] want,
                               input logic [32:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            err_total++;
        end
    endtask

    always @(posedge aclk) begin
        pes_result_t want;
        if (!aresetn) begin
            result_q.delete();
            hdr_pos  = '0;
            skipping = 1'b0;
            id_q     = '0;
            len_q    = '0;
            flags_q  = '0;
            hlen_q   = '0;
            pts_q    = '0;
            dts_q    = '0;
        end else begin
            if (s_valid && s_ready)
                predict_byte(s_data_byte, s_last_byte);
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("result with none pending: status %0d", m_status);
                    err_total++;
                end else begin
                    want = result_q.pop_front();
                    check_field("status", {31'd0, want.status}, {31'd0, m_status});
                    check_field("stream_id", {25'd0, want.stream_id}, {25'd0, m_stream_id});
                    check_field("id_supported", {32'd0, want.id_supported},
                                {32'd0, m_id_supported});
                    check_field("pes_length", {17'd0, want.pes_length},
                                {17'd0, m_pes_length});
                    check_field("payload_offset", {24'd0, want.payload_offset},
                                {24'd0, m_payload_offset});
                    check_field("have_pts", {32'd0, want.have_pts}, {32'd0, m_have_pts});
                    check_field("pts", want.pts, m_pts);
                    check_field("have_dts", {32'd0, want.have_dts}, {32'd0, m_have_dts});
                    check_field("dts", want.dts, m_dts);
                end
            end
        end
        outstanding <= result_q.size();
    end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives PES packets into the header parser: a few hand-built packets, then
// random well-formed, corrupted, truncated and noise packets under three
// idling mixes. The checker predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb;

    localparam int STALL_LIMIT = 3000;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [1:0]  m_status;
    logic [7:0]  m_stream_id;
    logic        m_id_supported;
    logic [15:0] m_pes_length;
    logic [8:0]  m_payload_offset;
    logic        m_have_pts;
    logic [32:0] m_pts;
    logic        m_have_dts;
    logic [32:0] m_dts;

    int          fail_total;
    int          pending;
    int          snd_idle    = 0;
    int          rcv_idle    = 0;
    int          stall_cycles = 0;
    logic [7:0]  pkt_buf [$];

    pes_header_parser_top DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_stream_id      (m_stream_id),
        .m_id_supported   (m_id_supported),
        .m_pes_length     (m_pes_length),
        .m_payload_offset (m_payload_offset),
        .m_have_pts       (m_have_pts),
        .m_pts            (m_pts),
        .m_have_dts       (m_have_dts),
        .m_dts            (m_dts)
    );

    pes_result_checker u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_stream_id      (m_stream_id),
        .m_id_supported   (m_id_supported),
        .m_pes_length     (m_pes_length),
        .m_payload_offset (m_payload_offset),
        .m_have_pts       (m_have_pts),
        .m_pts            (m_pts),
        .m_have_dts       (m_have_dts),
        .m_dts            (m_dts),
        .mismatches       (fail_total),
        .outstanding      (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(0, 99) >= rcv_idle);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("pes_header_parser_top: mismatch");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < snd_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_buf.size(); i++)
            push_byte(pkt_buf[i], i == pkt_buf.size() - 1);
    endtask

    // hold the sender off until every pending result has come out
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic chop_to(input int keep);
        while (pkt_buf.size() > keep) void'(pkt_buf.pop_back());
    endtask

    task automatic build_packet(output int counted);
        int         hl;
        int         mode;
        int         k;
        logic [7:0] v;
        logic [1:0] mk;
        logic [15:0] plen;
        pkt_buf.delete();
        mode = $urandom_range(0, 99);
        if (mode >= 97) begin
            // line noise
            repeat ($urandom_range(1, 12)) pkt_buf.push_back(8'($urandom_range(0, 255)));
            counted = pkt_buf.size();
        end else begin
            k = $urandom_range(0, 99);
            if (k < 2)
                hl = 255;
            else if (k < 4)
                hl = $urandom_range(15, 254);
            else
                hl = $urandom_range(0, 14);
            case ($urandom_range(0, 15))
                0: v = 8'hbc;
                1: v = 8'hbd;
                2: v = 8'hbe;
                3: v = 8'hbf;
                4: v = 8'hc0;
                5: v = 8'hdf;
                6: v = 8'he0;
                7: v = 8'hef;
                8: v = 8'hf0;
                default: v = 8'($urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 4) == 0)
                plen = 16'($urandom_range(0, hl + 6));
            else
                plen = 16'($urandom_range(0, 65535));
            pkt_buf = '{8'h00, 8'h00, 8'h01};
            pkt_buf.push_back(v);
            pkt_buf.push_back(plen[15:8]);
            pkt_buf.push_back(plen[7:0]);
            pkt_buf.push_back({2'b10, 6'($urandom_range(0, 63))});
            pkt_buf.push_back(8'($urandom_range(0, 255)));
            pkt_buf.push_back(8'(hl));
            repeat (hl) pkt_buf.push_back(8'($urandom_range(0, 255)));
            counted = 9 + hl;
            repeat ($urandom_range(0, 4)) pkt_buf.push_back(8'($urandom_range(0, 255)));

            if (mode >= 65 && mode < 75) begin
                k = $urandom_range(0, 2);
                if (k < 2) begin
                    pkt_buf[k] = 8'($urandom_range(1, 255));
                end else begin
                    v = 8'($urandom_range(0, 254));
                    if (v != 8'h00) v = v + 8'd1;
                    pkt_buf[2] = v;
                end
                counted = k + 1;
            end else if (mode >= 75 && mode < 85) begin
                mk = 2'($urandom_range(0, 2));
                if (mk == 2'b10) mk = 2'b11;
                pkt_buf[6] = {mk, 6'($urandom_range(0, 63))};
                counted = 7;
            end
            if (mode >= 85) begin
                k = $urandom_range(1, 8 + hl);
                chop_to(k);
                counted = k;
            end else if (mode >= 65 && $urandom_range(0, 2) == 0) begin
                // corrupted and cut short, sometimes right on the bad byte
                k = $urandom_range(1, counted);
                chop_to(k);
                counted = k;
            end
        end
        // bytes that will actually be driven
        counted = pkt_buf.size();
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input int quota);
        int sent;
        int n;
        snd_idle = s_pct;
        rcv_idle = r_pct;
        sent     = 0;
        while (sent < quota) begin
            build_packet(n);
            send_packet();
            sent += n;
        end
        drain();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        snd_idle = 14;
        rcv_idle = 60;
        // bad prefix on the only byte
        pkt_buf = '{8'h01};
        send_packet();
        // bad marker on the last byte
        pkt_buf = '{8'h00, 8'h00, 8'h01, 8'hbd, 8'h00, 8'h00, 8'h40};
        send_packet();
        // packet ends inside the prefix
        pkt_buf = '{8'h00, 8'h00};
        send_packet();
        // pts and dts all ones, full length, header ends on the last byte
        pkt_buf = '{8'h00, 8'h00, 8'h01, 8'he0, 8'hff, 8'hff, 8'hbf, 8'hc0, 8'h0a,
                    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
        send_packet();
        // empty optional header with pts flag set: no time stamp
        pkt_buf = '{8'h00, 8'h00, 8'h01, 8'hc0, 8'h00, 8'h00, 8'h80, 8'h80, 8'h00};
        send_packet();
        drain();

        run_phase(14, 60, 570);
        run_phase(60, 14, 570);
        run_phase(0, 0, 570);

        repeat (12) @(posedge aclk);
        if (fail_total == 0)
            $display("pes_header_parser_top: match");
        else
            $display("pes_header_parser_top: mismatch");
        $finish;
    end

endmodule
